// ===== hdl/elfh_pkg.sv =====
// Shared types, constants and the bucket-count function of the ELF hash table builder.
`timescale 1ns / 1ps

package elfh_pkg;

  localparam int unsigned HASH_W       = 28;
  localparam int unsigned SYM_W        = 12;
  localparam int unsigned COUNT_W      = 13;
  localparam int unsigned BUCKET_DEPTH = 2053;
  localparam int unsigned BUCKET_W     = $clog2(BUCKET_DEPTH);
  localparam int unsigned DIV_CNT_W    = $clog2(HASH_W);
  localparam int unsigned QUEUE_DEPTH  = 2;
  localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  // One finished name: its reduced-to-28-bit hash and the symbol index.
  typedef struct packed {
    logic [HASH_W-1:0] hash;
    logic [SYM_W-1:0]  sym;
  } req_t;

  // Back end sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_LOOKUP
  } back_state_e;

  // Pick the bucket count from the prime list.
  function automatic logic [BUCKET_W-1:0] bucket_total(input logic [COUNT_W-1:0] count);
    logic [BUCKET_W-1:0] nb;
    if (count < COUNT_W'(3))         nb = BUCKET_W'(1);
    else if (count < COUNT_W'(17))   nb = BUCKET_W'(3);
    else if (count < COUNT_W'(37))   nb = BUCKET_W'(17);
    else if (count < COUNT_W'(67))   nb = BUCKET_W'(37);
    else if (count < COUNT_W'(97))   nb = BUCKET_W'(67);
    else if (count < COUNT_W'(131))  nb = BUCKET_W'(97);
    else if (count < COUNT_W'(197))  nb = BUCKET_W'(131);
    else if (count < COUNT_W'(263))  nb = BUCKET_W'(197);
    else if (count < COUNT_W'(521))  nb = BUCKET_W'(263);
    else if (count < COUNT_W'(1031)) nb = BUCKET_W'(521);
    else if (count < COUNT_W'(2053)) nb = BUCKET_W'(1031);
    else                             nb = BUCKET_W'(2053);
    return nb;
  endfunction

endpackage

// ===== hdl/elfh_front.sv =====
// Front end: folds name bytes into the ELF hash and queues finished names.
`timescale 1ns / 1ps

module elfh_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        enable_i,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  logic [7:0]                  name_byte_i,
  input  logic [elfh_pkg::SYM_W-1:0]  symbol_index_i,
  input  logic                        full_i,
  output logic                        push_o,
  output elfh_pkg::req_t              push_data_o
);

  logic [elfh_pkg::HASH_W-1:0] acc_q, acc_d;
  logic [31:0]                 sum;
  logic [3:0]                  top_nib;
  logic                        accept;
  logic                        is_term;

  assign ready_o = enable_i && !full_i;
  assign accept  = valid_i && ready_o;
  assign is_term = (name_byte_i == 8'd0);

  // h = (h << 4) + byte, then fold the top nibble back in at bit 4 and drop it.
  assign sum     = {acc_q, 4'b0000} + {24'd0, name_byte_i};
  assign top_nib = sum[31:28];

  always_comb begin
    acc_d = acc_q;
    if (accept) begin
      if (is_term) begin
        acc_d = '0;
      end else begin
        acc_d = sum[27:0] ^ {20'd0, top_nib, 4'b0000};
      end
    end
  end

  assign push_o           = accept && is_term;
  assign push_data_o.hash = acc_q;
  assign push_data_o.sym  = symbol_index_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

endmodule

// ===== hdl/elfh_queue.sv =====
// Short request queue between the hashing front end and the table back end.
`timescale 1ns / 1ps

module elfh_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  elfh_pkg::req_t push_data_i,
  input  logic           pop_i,
  output elfh_pkg::req_t head_o,
  output logic           full_o,
  output logic           empty_o
);

  elfh_pkg::req_t                  entries_q [elfh_pkg::QUEUE_DEPTH];
  logic [elfh_pkg::QPTR_W-1:0]     wr_ptr_q, rd_ptr_q;
  logic [elfh_pkg::QCNT_W-1:0]     count_q;
  logic                            do_push, do_pop;

  assign full_o  = (count_q == elfh_pkg::QCNT_W'(elfh_pkg::QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == elfh_pkg::QPTR_W'(elfh_pkg::QUEUE_DEPTH - 1)) ? '0
                    : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == elfh_pkg::QPTR_W'(elfh_pkg::QUEUE_DEPTH - 1)) ? '0
                    : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/elfh_back.sv =====
// Back end: bucket modulo, last-position store lookup and table write requests.
`timescale 1ns / 1ps

module elfh_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [elfh_pkg::COUNT_W-1:0]  symbol_count_i,
  input  logic                          empty_i,
  input  elfh_pkg::req_t                head_i,
  output logic                          pop_o,
  output logic                          clearing_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          is_chain_o,
  output logic [elfh_pkg::SYM_W-1:0]    entry_index_o,
  output logic [elfh_pkg::SYM_W-1:0]    entry_value_o
);

  elfh_pkg::back_state_e state_q, state_d;

  logic [elfh_pkg::SYM_W-1:0]      mem [elfh_pkg::BUCKET_DEPTH];
  logic                            mem_we;
  logic [elfh_pkg::BUCKET_W-1:0]   mem_waddr;
  logic [elfh_pkg::SYM_W-1:0]      mem_wdata;
  logic [elfh_pkg::SYM_W-1:0]      rd_q;

  logic [elfh_pkg::BUCKET_W-1:0]   clr_q;
  logic [elfh_pkg::HASH_W-1:0]     div_q;
  logic [elfh_pkg::BUCKET_W-1:0]   rem_q, rem_d;
  logic [elfh_pkg::BUCKET_W-1:0]   divisor_q;
  logic [elfh_pkg::DIV_CNT_W-1:0]  cnt_q;
  logic [elfh_pkg::SYM_W-1:0]      sym_q;
  logic [elfh_pkg::BUCKET_W:0]     trial;

  logic                            out_valid_q;
  logic                            is_chain_q;
  logic [elfh_pkg::SYM_W-1:0]      entry_index_q, entry_value_q;
  logic                            slot_free;
  logic                            load_out;

  assign slot_free = !out_valid_q || out_ready_i;

  // One restoring division step per cycle; the remainder always stays below the divisor.
  assign trial = {rem_q, div_q[elfh_pkg::HASH_W-1]};
  always_comb begin
    if (trial >= {1'b0, divisor_q}) begin
      rem_d = elfh_pkg::BUCKET_W'(trial - {1'b0, divisor_q});
    end else begin
      rem_d = trial[elfh_pkg::BUCKET_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= elfh_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    pop_o      = 1'b0;
    load_out   = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = clr_q;
    mem_wdata  = '0;
    clearing_o = 1'b0;
    case (state_q)
      elfh_pkg::ST_CLEAR: begin
        clearing_o = 1'b1;
        mem_we     = 1'b1;
        if (clr_q == elfh_pkg::BUCKET_W'(elfh_pkg::BUCKET_DEPTH - 1)) begin
          state_d = elfh_pkg::ST_IDLE;
        end
      end
      elfh_pkg::ST_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          state_d = elfh_pkg::ST_DIV;
        end
      end
      elfh_pkg::ST_DIV: begin
        if (cnt_q == '0) begin
          state_d = elfh_pkg::ST_READ;
        end
      end
      elfh_pkg::ST_READ: begin
        state_d = elfh_pkg::ST_LOOKUP;
      end
      elfh_pkg::ST_LOOKUP: begin
        if (slot_free) begin
          load_out  = 1'b1;
          mem_we    = 1'b1;
          mem_waddr = rem_q;
          mem_wdata = sym_q;
          state_d   = elfh_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = elfh_pkg::ST_CLEAR;
      end
    endcase
  end

  // Last-position store, one write and one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (state_q == elfh_pkg::ST_READ) begin
      rd_q <= mem[rem_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (state_q == elfh_pkg::ST_CLEAR) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      div_q     <= head_i.hash;
      sym_q     <= head_i.sym;
      rem_q     <= '0;
      divisor_q <= elfh_pkg::bucket_total(symbol_count_i);
      cnt_q     <= elfh_pkg::DIV_CNT_W'(elfh_pkg::HASH_W - 1);
    end else if (state_q == elfh_pkg::ST_DIV) begin
      div_q <= div_q << 1;
      rem_q <= rem_d;
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // A stored position of zero reads as empty: write the bucket head then.
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      is_chain_q    <= (rd_q != '0);
      entry_index_q <= (rd_q != '0) ? rd_q : elfh_pkg::SYM_W'(rem_q);
      entry_value_q <= sym_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign is_chain_o    = is_chain_q;
  assign entry_index_o = entry_index_q;
  assign entry_value_o = entry_value_q;

endmodule

// ===== hdl/elf_symbol_hash_table_builder.sv =====
// Top level of the System V ELF symbol hash table builder.
`timescale 1ns / 1ps

// Stream in the name bytes of each symbol, one request per byte, ending with a
// zero byte that carries the symbol index; the front end folds each nonzero
// byte into the classic ELF hash as it is accepted. Each terminator queues the
// hash and index (queue depth two) for the back end, which reduces the hash
// modulo the bucket count with a bit-serial divider, reads the last-position
// store, and then emits one table write request before it takes the next
// symbol; that divider sets the sustained rate for short names. The bucket
// count follows the symbol_count register (APB address 0) through the prime
// list, sampled when a symbol enters the divider. An output request with tuser
// high is a chain write (chain[entry_index] = entry_value), with tuser low a
// bucket head write (bucket[entry_index] = entry_value). After reset all 2053
// entries of the store are cleared, during which s_axis_tready stays low;
// configuration writes are taken at any time, but change symbol_count only
// while the block is idle.

module elf_symbol_hash_table_builder (
  input  logic        clk_i,
  input  logic        rst_ni,

  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,

  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [7:0] name_byte, [19:8] symbol_index, [23:20] zero

  // Output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [11:0] entry_index, [23:12] entry_value
  output logic        m_axis_tuser    // [0] is_chain
);

  logic [elfh_pkg::COUNT_W-1:0] symbol_count_q;
  logic                         cfg_write;
  logic                         sel_count;

  logic                         push;
  elfh_pkg::req_t               push_data;
  elfh_pkg::req_t               head;
  logic                         full, empty, pop;
  logic                         clearing;
  logic                         is_chain;
  logic [elfh_pkg::SYM_W-1:0]   entry_index, entry_value;

  // Configuration register; only bit 2 of paddr selects a register.
  assign pready    = 1'b1;
  assign sel_count = (paddr[2] == 1'b0);
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = sel_count ? {{(32 - elfh_pkg::COUNT_W){1'b0}}, symbol_count_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      symbol_count_q <= '0;
    end else if (cfg_write && sel_count) begin
      symbol_count_q <= pwdata[elfh_pkg::COUNT_W-1:0];
    end
  end

  elfh_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .enable_i       (!clearing),
    .valid_i        (s_axis_tvalid),
    .ready_o        (s_axis_tready),
    .name_byte_i    (s_axis_tdata[7:0]),
    .symbol_index_i (s_axis_tdata[19:8]),
    .full_i         (full),
    .push_o         (push),
    .push_data_o    (push_data)
  );

  elfh_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .full_o      (full),
    .empty_o     (empty)
  );

  elfh_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .symbol_count_i (symbol_count_q),
    .empty_i        (empty),
    .head_i         (head),
    .pop_o          (pop),
    .clearing_o     (clearing),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .is_chain_o     (is_chain),
    .entry_index_o  (entry_index),
    .entry_value_o  (entry_value)
  );

  assign m_axis_tdata = {entry_value, entry_index};
  assign m_axis_tuser = is_chain;

endmodule

// ===== test/elf_hash_table_checker.sv =====
// Watches the request streams of the hash table builder, predicts each table write and compares.
`timescale 1ns / 1ps

module elf_hash_table_checker #(
  parameter logic [2:0] COUNT_ADDR = 3'd0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  input  logic               s_axis_tvalid,
  input  logic               s_axis_tready,
  input  logic [23:0]        s_axis_tdata,   // [7:0] name_byte, [19:8] symbol_index
  input  logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  input  logic [23:0]        m_axis_tdata,   // [11:0] entry_index, [23:12] entry_value
  input  logic               m_axis_tuser,   // [0] is_chain
  output int unsigned        mismatch_cnt_o,
  output int unsigned        pending_o
);

  localparam logic WR_BUCKET = 1'b0;
  localparam logic WR_CHAIN  = 1'b1;
  localparam int unsigned PRIMES [12] = '{1, 3, 17, 37, 67, 97, 131, 197, 263, 521, 1031, 2053};

  typedef struct packed {
    logic                       chain;
    logic [elfh_pkg::SYM_W-1:0] idx;
    logic [elfh_pkg::SYM_W-1:0] val;
  } table_write_t;

  table_write_t                 table_writes_q [$];
  logic [elfh_pkg::HASH_W-1:0]  name_hash;
  logic [elfh_pkg::SYM_W-1:0]   last_pos [elfh_pkg::BUCKET_DEPTH];
  logic [elfh_pkg::COUNT_W-1:0] sym_count;
  int unsigned                  mismatches = 0;

  assign mismatch_cnt_o = mismatches;

  task automatic flag(input string what);
    $display("%0t: mismatch: %s", $time, what);
    mismatches++;
  endtask

  // Largest prime of the list that the count reaches, one bucket below three.
  function automatic int unsigned buckets_for(input logic [elfh_pkg::COUNT_W-1:0] n);
    int unsigned nb;
    nb = PRIMES[0];
    for (int k = 1; k < 12; k++) begin
      if (n >= PRIMES[k]) nb = PRIMES[k];
    end
    return nb;
  endfunction

  // Shift in a byte; the nibble pushed out at the top folds back in at bits 7:4.
  function automatic logic [elfh_pkg::HASH_W-1:0] fold_byte(
    input logic [elfh_pkg::HASH_W-1:0] acc,
    input logic [7:0]                  c);
    logic [31:0] h;
    h = {acc, 4'h0} + 32'(c);
    h[7:4] = h[7:4] ^ h[31:28];
    return h[elfh_pkg::HASH_W-1:0];
  endfunction

  task automatic take_request(input logic [7:0] c, input logic [elfh_pkg::SYM_W-1:0] sym);
    int unsigned  b;
    table_write_t w;
    if (c != 8'h00) begin
      name_hash = fold_byte(name_hash, c);
      return;
    end
    b = name_hash % buckets_for(sym_count);
    // A stored position of zero reads as an empty bucket.
    if (last_pos[b] != '0) begin
      w.chain = WR_CHAIN;
      w.idx   = last_pos[b];
    end else begin
      w.chain = WR_BUCKET;
      w.idx   = elfh_pkg::SYM_W'(b);
    end
    w.val = sym;
    table_writes_q.insert(table_writes_q.size(), w);
    last_pos[b] = sym;
    name_hash   = '0;
  endtask

  task automatic check_write(input logic chain, input logic [23:0] data);
    table_write_t want;
    if (table_writes_q.size() == 0) begin
      flag($sformatf("unexpected write chain=%b data=%h", chain, data));
      return;
    end
    want = table_writes_q.pop_front();
    if (chain !== want.chain)
      flag($sformatf("is_chain %b, want %b", chain, want.chain));
    if (data[11:0] !== want.idx)
      flag($sformatf("entry_index %0d, want %0d", data[11:0], want.idx));
    if (data[23:12] !== want.val)
      flag($sformatf("entry_value %0d, want %0d", data[23:12], want.val));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (last_pos[i]) last_pos[i] = '0;
      table_writes_q.delete();
      name_hash = '0;
      sym_count = '0;
      pending_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == COUNT_ADDR)
        sym_count = pwdata[elfh_pkg::COUNT_W-1:0];
      if (s_axis_tvalid && s_axis_tready)
        take_request(s_axis_tdata[7:0], s_axis_tdata[19:8]);
      if (m_axis_tvalid && m_axis_tready)
        check_write(m_axis_tuser, m_axis_tdata);
      pending_o <= table_writes_q.size();
    end
  end

endmodule

// ===== test/elf_symbol_hash_table_builder_tb.sv =====
// Top of the testbench: clock, reset, name stimulus, register writes and the verdict.
`timescale 1ns / 1ps

module elf_symbol_hash_table_builder_tb;

  localparam logic [2:0]  ADDR_SYMBOL_COUNT = 3'd0;
  localparam logic [2:0]  ADDR_UNMAPPED     = 3'd4;
  localparam int unsigned N_PHASES          = 8;
  localparam int unsigned ITEMS_PER_PHASE   = 216;
  // Back end handles one symbol at a time with up to two queued; leave room.
  localparam int unsigned SETTLE_CYCLES     = 80;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // [7:0] name_byte, [19:8] symbol_index, [23:20] zero
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // [11:0] entry_index, [23:12] entry_value
  logic        m_axis_tuser;   // [0] is_chain

  int unsigned mismatch_cnt;
  int unsigned pending;
  int unsigned tx_idle_pct = 27;
  int unsigned rx_idle_pct = 53;
  int unsigned items_sent  = 0;

  elf_symbol_hash_table_builder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  elf_hash_table_checker #(
    .COUNT_ADDR (ADDR_SYMBOL_COUNT)
  ) checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tuser   (m_axis_tuser),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Hard stop: covers the clearing pass plus every item at its slowest,
  // several times over.
  initial begin
    #8_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Receiver side: drop tready at random according to the current phase.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Mostly printable name bytes, the rest anywhere in 1..255.
  function automatic logic [7:0] rand_name_byte();
    if ($urandom_range(0, 99) < 60) return 8'($urandom_range(8'h21, 8'h7e));
    return 8'($urandom_range(1, 255));
  endfunction

  // Favor index zero (reads as empty) and the top index.
  function automatic logic [elfh_pkg::SYM_W-1:0] rand_sym();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 15) return '1;
    return elfh_pkg::SYM_W'($urandom_range(0, 4095));
  endfunction

  // Mostly short names, some long enough to wrap the hash, a few empty.
  function automatic int unsigned rand_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4)  return 0;
    if (r < 70) return $urandom_range(1, 8);
    return $urandom_range(9, 24);
  endfunction

  // Present one request, idling first at random; hold tvalid until accepted.
  task automatic send_req(input logic [7:0] c, input logic [elfh_pkg::SYM_W-1:0] sym);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'h0, sym, c};
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  // Name bytes carry a random index, which the block ignores until the terminator.
  task automatic send_name(input int unsigned len, input logic [elfh_pkg::SYM_W-1:0] sym);
    for (int unsigned i = 0; i < len; i++) send_req(rand_name_byte(), rand_sym());
    send_req(8'h00, sym);
  endtask

  // Drop tvalid, wait for every predicted write, then let the back end settle.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Setup cycle, then access cycle; pready is always high.
  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    logic [31:0] counts [N_PHASES];
    int unsigned phase_end;
    bit          paused;

    counts = '{32'd4096, 32'd2, 32'd3, 32'hFFFF_E024, 32'd8191, 32'd300, 32'd1100,
               32'($urandom_range(0, 8191))};
    paused = 1'b0;

    rst_ni        <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, one bucket: everything lands in bucket 0.
    apb_write(ADDR_SYMBOL_COUNT, 32'd0);
    send_req(8'h00, 12'd0);        // empty name, index zero
    send_req(8'h00, 12'd5);        // zero still reads empty: head again
    send_req(8'h00, 12'hFFF);      // chain behind index 5
    for (int i = 0; i < 8; i++) send_req(8'hFF, 12'hFFF);  // top nibble folds back
    send_req(8'h00, 12'd1);
    send_req(8'h01, 12'h000);
    send_req(8'h80, 12'hAAA);
    send_req(8'h00, 12'h800);
    wait_drained();

    // Largest table; bucket 0 keeps its last position from above.
    apb_write(ADDR_SYMBOL_COUNT, 32'd4096);
    send_req(8'h6d, 12'h555);
    send_req(8'h61, 12'h555);
    send_req(8'h69, 12'h555);
    send_req(8'h6e, 12'h555);
    send_req(8'h00, 12'd2);
    send_req(8'h00, 12'd3);

    // Random phases: sender 27 / receiver 53 idle, then swapped, then none.
    for (int p = 0; p < N_PHASES; p++) begin
      wait_drained();
      if (p < 3) begin
        tx_idle_pct = 27;
        rx_idle_pct = 53;
      end else if (p < 6) begin
        tx_idle_pct = 53;
        rx_idle_pct = 27;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      apb_write(ADDR_SYMBOL_COUNT, counts[p]);
      // Unmapped address must leave symbol_count alone.
      if (p == 5) apb_write(ADDR_UNMAPPED, 32'd5);

      phase_end = items_sent + ITEMS_PER_PHASE;
      while (items_sent < phase_end) begin
        send_name(rand_len(), rand_sym());
        // Hold off the sender once until the block has emptied.
        if (p == 1 && !paused && items_sent + ITEMS_PER_PHASE / 2 >= phase_end) begin
          wait_drained();
          paused = 1'b1;
        end
      end
      // Leave a name half sent so the next count applies mid-name.
      repeat ($urandom_range(0, 3)) send_req(rand_name_byte(), rand_sym());
    end

    wait_drained();
    if (mismatch_cnt == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== elf_symbol_hash_table_builder.f =====
hdl/elfh_pkg.sv
hdl/elfh_front.sv
hdl/elfh_queue.sv
hdl/elfh_back.sv
hdl/elf_symbol_hash_table_builder.sv
test/elf_hash_table_checker.sv
test/elf_symbol_hash_table_builder_tb.sv
